// ===== design/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants for the matrix multiply engine: field widths,
// controller states and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package mme_pkg;

	// default matrix dimension
	localparam int DIM_DEFAULT = 16;

	// fixed field widths
	localparam int IDX_IN_W = 4;
	localparam int ELEM_W   = 16;
	localparam int PROD_W   = 2 * ELEM_W;
	localparam int ACC_W    = 48;

	// item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic issue;
		logic last;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_done;
	} dp_status_t;

endpackage

// ===== design/matrix_multiply_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Square matrix product C = A x B over signed Q8.8 elements; each read item
// returns one element of C as an exact signed Q32.16 dot product.
//
//   channel   handshake        payload
//   input     start / busy     mode, row, col, a_value, b_value
//   result    done (strobe)    product_value
//
// A load item leaves busy low.
// A read item holds busy after it is accepted: the ISSUE state walks the inner
// index through the A and B store read ports, then DRAIN waits for the read and
// multiply stages to fill; done pulses for one cycle as busy falls.
// Reset clears control state only; element stores hold nothing defined until
// written. The result side has no stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
	parameter int DIM = mme_pkg::DIM_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 mode,
	input  logic [mme_pkg::IDX_IN_W-1:0]         row,
	input  logic [mme_pkg::IDX_IN_W-1:0]         col,
	input  logic signed [mme_pkg::ELEM_W-1:0]    a_value,
	input  logic signed [mme_pkg::ELEM_W-1:0]    b_value,
	output logic signed [mme_pkg::ACC_W-1:0]     product_value,
	output logic                                 done
);

	mme_pkg::ctl_cmd_t         cmd;
	mme_pkg::dp_status_t       status;
	logic [$clog2(DIM)-1:0]    k;
	logic                      load_en;

	// load items write straight into the stores
	assign load_en = start && !busy && (mode == mme_pkg::MODE_LOAD);

	// sequencer
	mme_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.cmd    (cmd),
		.k      (k),
		.busy   (busy)
	);

	// stores and multiply-accumulate
	mme_datapath #(
		.DIM(DIM)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_en       (load_en),
		.row           (row),
		.col           (col),
		.a_value       (a_value),
		.b_value       (b_value),
		.cmd           (cmd),
		.k             (k),
		.status        (status),
		.product_value (product_value),
		.done          (done)
	);

	// result strobe only once the walk has ended
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");

	// a read item always occupies the engine
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == mme_pkg::MODE_READ)) |=> busy)
		else $error("read item did not raise busy");

	// a load item never occupies the engine
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == mme_pkg::MODE_LOAD)) |=> !busy)
		else $error("load item raised busy");

	// a result follows a busy period
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("done without a preceding read");

endmodule

// ===== design/mme_ctrl.sv =====
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer for read items: walks the inner index over DIM steps, then waits
// for the multiply-accumulate pipeline to drain.
// ----------------------------------------------------------------------------
module mme_ctrl #(
	parameter int DIM = mme_pkg::DIM_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      mode,
	input  mme_pkg::dp_status_t       status,
	output mme_pkg::ctl_cmd_t         cmd,
	output logic [$clog2(DIM)-1:0]    k,
	output logic                      busy
);

	localparam int IDX_W = $clog2(DIM);
	localparam logic [IDX_W-1:0] K_LAST = IDX_W'(DIM - 1);

	mme_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] k_q;
	logic             accept;
	logic             k_last;

	assign accept = start && (state_q == mme_pkg::ST_IDLE);
	assign k_last = (k_q == K_LAST);
	assign k      = k_q;

	// state register and inner index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mme_pkg::ST_ISSUE) begin
				k_q <= k_last ? '0 : k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				if (accept && (mode == mme_pkg::MODE_READ)) begin
					state_d = mme_pkg::ST_ISSUE;
				end
			end
			mme_pkg::ST_ISSUE: begin
				if (k_last) begin
					state_d = mme_pkg::ST_DRAIN;
				end
			end
			mme_pkg::ST_DRAIN: begin
				if (status.last_done) begin
					state_d = mme_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mme_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd.capture = 1'b0;
		cmd.issue   = 1'b0;
		cmd.last    = 1'b0;
		busy        = 1'b1;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = accept && (mode == mme_pkg::MODE_READ);
			end
			mme_pkg::ST_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.last  = k_last;
			end
			mme_pkg::ST_DRAIN: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== design/mme_datapath.sv =====
// ----------------------------------------------------------------------------
// mme_datapath
// Element stores for A and B, registered reads, one multiplier stage, a
// 48-bit accumulator and the registered result.
// ----------------------------------------------------------------------------
module mme_datapath #(
	parameter int DIM = mme_pkg::DIM_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load_en,
	input  logic [mme_pkg::IDX_IN_W-1:0]         row,
	input  logic [mme_pkg::IDX_IN_W-1:0]         col,
	input  logic signed [mme_pkg::ELEM_W-1:0]    a_value,
	input  logic signed [mme_pkg::ELEM_W-1:0]    b_value,
	input  mme_pkg::ctl_cmd_t                    cmd,
	input  logic [$clog2(DIM)-1:0]               k,
	output mme_pkg::dp_status_t                  status,
	output logic signed [mme_pkg::ACC_W-1:0]     product_value,
	output logic                                 done
);

	localparam int IDX_W     = $clog2(DIM);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	logic signed [mme_pkg::ELEM_W-1:0] mem_a [MEM_DEPTH];
	logic signed [mme_pkg::ELEM_W-1:0] mem_b [MEM_DEPTH];

	logic [IDX_W-1:0] row_i, col_i;
	logic             in_range;
	logic [IDX_W-1:0] row_q, col_q;
	logic             in_range_q;

	logic signed [mme_pkg::ELEM_W-1:0] a_rd_s1, b_rd_s1;
	logic                              valid_s1, last_s1;
	logic signed [mme_pkg::PROD_W-1:0] prod_s2;
	logic                              valid_s2, last_s2;
	logic signed [mme_pkg::ACC_W-1:0]  acc_q, acc_sum;
	logic signed [mme_pkg::ACC_W-1:0]  product_q;
	logic                              done_q;

	// index checks against the matrix size
	assign row_i    = IDX_W'(row);
	assign col_i    = IDX_W'(col);
	assign in_range = (32'(row) < DIM) && (32'(col) < DIM);

	// element stores: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (load_en && in_range) begin
			mem_a[{row_i, col_i}] <= a_value;
			mem_b[{row_i, col_i}] <= b_value;
		end
		if (cmd.issue) begin
			a_rd_s1 <= mem_a[{row_q, k}];
			b_rd_s1 <= mem_b[{k, col_q}];
		end
	end

	// read item indices held for the whole walk
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q      <= row_i;
			col_q      <= col_i;
			in_range_q <= in_range;
		end
	end

	// multiplier stage
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

	// pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			last_s1  <= cmd.issue && cmd.last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			done_q   <= valid_s2 && last_s2;
		end
	end

	assign acc_sum = acc_q + mme_pkg::ACC_W'(prod_s2);

	// accumulator and result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_sum;
		end
		if (valid_s2 && last_s2) begin
			product_q <= in_range_q ? acc_sum : '0;
		end
	end

	assign status.last_done = valid_s2 && last_s2;
	assign product_value    = product_q;
	assign done             = done_q;

endmodule
